[sv/mfs_pkg.sv]
// Shared constants, types and helper functions of the multilevel feedback scheduler.
package mfs_pkg;

  localparam int unsigned MaxTasks  = 64;
  localparam int unsigned MaxLevels = 5;
  localparam int unsigned IdW       = $clog2(MaxTasks);
  localparam int unsigned LvW       = $clog2(MaxLevels);
  localparam int unsigned CntW      = IdW + 1;
  localparam int unsigned QAddrW    = LvW + IdW;

  // Configuration register indexes.
  localparam logic [1:0] RegLevelCount = 2'd0;
  localparam logic [1:0] RegBoostPer   = 2'd1;
  localparam logic [1:0] RegSlices     = 2'd2;
  localparam logic [1:0] RegAllots     = 2'd3;

  // Input operation codes.
  localparam logic FuncArrive = 1'b0;
  localparam logic FuncTick   = 1'b1;

  // Per-task record held in the task memory.
  typedef struct packed {
    logic [15:0] burst;
    logic [31:0] stamp;
    logic [7:0]  slice;
    logic [15:0] allot;
  } task_rec_t;

  typedef enum logic [3:0] {
    StIdle,
    StArrive,
    StScan,
    StReadQ,
    StReadTask,
    StUpdate,
    StRequeue,
    StBoostRead,
    StBoostWrite,
    StDone
  } state_e;

  // Effective number of levels in use: 0 acts as 1, above MaxLevels clamps.
  function automatic logic [LvW:0] levels_used(input logic [2:0] lc);
    logic [LvW:0] n;
    n = (LvW + 1)'(lc);
    if (lc == 3'd0) n = (LvW + 1)'(1);
    if (32'(lc) > MaxLevels) n = (LvW + 1)'(MaxLevels);
    return n;
  endfunction

  function automatic logic is_last(input logic [LvW-1:0] lv, input logic [2:0] lc);
    return ((LvW + 1)'(lv) + (LvW + 1)'(1)) >= levels_used(lc);
  endfunction

  function automatic logic [7:0] slice_of(input logic [LvW-1:0] lv, input logic [39:0] s);
    logic [7:0] v;
    v = (lv < LvW'(4)) ? s[8*lv +: 8] : s[39:32];
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [15:0] allot_of(input logic [LvW-1:0] lv, input logic [63:0] a);
    logic [15:0] v;
    v = (lv < LvW'(4)) ? a[16*lv +: 16] : 16'd0;
    if (lv < LvW'(4) && v == 16'd0) v = 16'd1;
    return v;
  endfunction

endpackage

[sv/multilevel_feedback_scheduler_core.sv]
// Top level of the multilevel feedback scheduler: control, task memory and level queues.
// An arrival passes StArrive then StDone; a tick passes StScan, StReadQ, StReadTask, StUpdate,
// an optional StRequeue and StDone, an idle tick skipping the reads; a boost walks the task table.
// The core takes one word at a time; busy stays high from acceptance to the result strobe,
// and after a boost period write while time modulo the period is rebuilt.
// Reset clears time, task count, queue heads and fills; memories need no clearing.
module multilevel_feedback_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        func_i,
  input  logic [15:0] burst_length_i,
  output logic        done_o,
  output logic [5:0]  task_id_o,
  output logic        ran_o,
  output logic        finished_o,
  output logic [31:0] turnaround_o,
  output logic [2:0]  run_level_o,
  output logic        table_full_o
);

  localparam int unsigned IdW = mfs_pkg::IdW;
  localparam int unsigned LvW = mfs_pkg::LvW;
  localparam int unsigned CntW = mfs_pkg::CntW;

  // Configuration registers.
  logic [2:0]  level_count_q;
  logic [15:0] boost_period_q;
  logic [39:0] slices_q;
  logic [63:0] allots_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q  <= 3'd3;
      boost_period_q <= 16'd100;
      slices_q       <= '0;
      allots_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mfs_pkg::RegLevelCount: level_count_q  <= cfg_data_i[2:0];
        mfs_pkg::RegBoostPer:   boost_period_q <= cfg_data_i[15:0];
        mfs_pkg::RegSlices:     slices_q       <= cfg_data_i[39:0];
        mfs_pkg::RegAllots:     allots_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Memories: task records and level queues.
  mfs_pkg::task_rec_t task_mem [mfs_pkg::MaxTasks];
  logic [IdW-1:0] q_mem [mfs_pkg::MaxLevels * mfs_pkg::MaxTasks];

  logic                  tm_we;
  logic [IdW-1:0]        tm_waddr, tm_raddr;
  mfs_pkg::task_rec_t    tm_wdata, tm_rdata_q;
  logic                  qm_we;
  logic [mfs_pkg::QAddrW-1:0] qm_waddr, qm_raddr;
  logic [IdW-1:0]        qm_wdata, qm_rdata_q;

  always_ff @(posedge clk_i) begin
    if (tm_we) task_mem[tm_waddr] <= tm_wdata;
    tm_rdata_q <= task_mem[tm_raddr];
    if (qm_we) q_mem[qm_waddr] <= qm_wdata;
    qm_rdata_q <= q_mem[qm_raddr];
  end

  // Control state.
  mfs_pkg::state_e state_q, state_d;
  logic [31:0]     time_q, time_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdW-1:0]  head_q [mfs_pkg::MaxLevels];
  logic [CntW-1:0] fill_q [mfs_pkg::MaxLevels];
  logic [IdW-1:0]  head_d [mfs_pkg::MaxLevels];
  logic [CntW-1:0] fill_d [mfs_pkg::MaxLevels];
  logic            func_q;
  logic [15:0]     burst_q;
  logic [LvW-1:0]  lv_q, lv_d;
  logic            found_q, found_d;
  logic [IdW-1:0]  id_q, id_d;
  logic            fin_q, fin_d;
  logic [31:0]     turn_q, turn_d;
  logic            full_q, full_d;
  logic            boost_q, boost_d;
  logic [CntW-1:0] walk_q, walk_d;
  mfs_pkg::task_rec_t upd_q, upd_d;
  logic [LvW-1:0]  rq_lv_q, rq_lv_d;
  logic            rq_q, rq_d;
  logic [15:0]     bmod_q, bmod_d;
  logic            accept;

  // Scan for the lowest non-empty level.
  logic           scan_found;
  logic [LvW-1:0] scan_lv;
  always_comb begin
    scan_found = 1'b0;
    scan_lv    = '0;
    for (int i = mfs_pkg::MaxLevels - 1; i >= 0; i--) begin
      if (fill_q[i] != '0) begin
        scan_found = 1'b1;
        scan_lv    = LvW'(i);
      end
    end
  end

  logic [15:0] period;
  assign period = (boost_period_q == 16'd0) ? 16'd1 : boost_period_q;

  // Serial remainder of time by a newly written boost period, one bit per cycle.
  logic        rem_busy_q;
  logic [4:0]  rem_cnt_q;
  logic [15:0] rem_q;
  logic [16:0] rem_shift;
  logic [15:0] rem_next;

  always_comb begin
    rem_shift = {rem_q, time_q[rem_cnt_q]};
    rem_next  = (rem_shift >= {1'b0, period}) ? 16'(rem_shift - {1'b0, period})
                                              : rem_shift[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_busy_q <= 1'b0;
      rem_cnt_q  <= '0;
      rem_q      <= '0;
    end else if (cfg_we_i && cfg_idx_i == mfs_pkg::RegBoostPer) begin
      rem_busy_q <= 1'b1;
      rem_cnt_q  <= 5'd31;
      rem_q      <= '0;
    end else if (rem_busy_q) begin
      rem_q     <= rem_next;
      rem_cnt_q <= rem_cnt_q - 5'd1;
      if (rem_cnt_q == 5'd0) rem_busy_q <= 1'b0;
    end
  end

  assign accept = start && !busy;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mfs_pkg::StIdle:      if (accept) begin
        state_d = (func_i == mfs_pkg::FuncArrive) ? mfs_pkg::StArrive : mfs_pkg::StScan;
      end
      mfs_pkg::StArrive:    state_d = mfs_pkg::StDone;
      mfs_pkg::StScan:      state_d = found_d ? mfs_pkg::StReadQ : mfs_pkg::StUpdate;
      mfs_pkg::StReadQ:     state_d = mfs_pkg::StReadTask;
      mfs_pkg::StReadTask:  state_d = mfs_pkg::StUpdate;
      mfs_pkg::StUpdate:    state_d = boost_d ? mfs_pkg::StBoostRead :
                                      (rq_d ? mfs_pkg::StRequeue : mfs_pkg::StDone);
      mfs_pkg::StRequeue:   state_d = mfs_pkg::StDone;
      mfs_pkg::StBoostRead: state_d = (walk_q == count_q) ? mfs_pkg::StDone
                                                          : mfs_pkg::StBoostWrite;
      mfs_pkg::StBoostWrite: state_d = mfs_pkg::StBoostRead;
      mfs_pkg::StDone:      state_d = mfs_pkg::StIdle;
      default:              state_d = mfs_pkg::StIdle;
    endcase
  end

  // Datapath and memory access logic.
  always_comb begin
    time_d  = time_q;
    count_d = count_q;
    head_d  = head_q;
    fill_d  = fill_q;
    lv_d    = lv_q;
    found_d = found_q;
    id_d    = id_q;
    fin_d   = fin_q;
    turn_d  = turn_q;
    full_d  = full_q;
    boost_d = boost_q;
    walk_d  = walk_q;
    upd_d   = upd_q;
    rq_lv_d = rq_lv_q;
    rq_d    = rq_q;
    bmod_d  = bmod_q;
    tm_we = 1'b0; tm_waddr = '0; tm_wdata = '0; tm_raddr = id_q;
    qm_we = 1'b0; qm_waddr = '0; qm_wdata = '0; qm_raddr = '0;
    unique case (state_q)
      mfs_pkg::StIdle: begin
        if (accept) begin
          found_d = 1'b0; fin_d = 1'b0; turn_d = '0; full_d = 1'b0;
          boost_d = 1'b0; rq_d = 1'b0; id_d = '0; lv_d = '0;
          // Track time modulo the boost period one step at a time; a time wrap lands on zero.
          if (func_i == mfs_pkg::FuncTick) begin
            if (time_q == 32'hFFFF_FFFF) begin
              bmod_d = 16'd0;
            end else begin
              bmod_d = (bmod_q + 16'd1 >= period) ? 16'd0 : bmod_q + 16'd1;
            end
          end
        end else if (rem_busy_q && rem_cnt_q == 5'd0) begin
          bmod_d = rem_next;
        end
      end
      mfs_pkg::StArrive: begin
        if (count_q == CntW'(mfs_pkg::MaxTasks)) begin
          full_d = 1'b1;
        end else begin
          id_d = count_q[IdW-1:0];
          tm_we = 1'b1;
          tm_waddr = count_q[IdW-1:0];
          tm_wdata.burst = (burst_q == 16'd0) ? 16'd1 : burst_q;
          tm_wdata.stamp = time_q;
          tm_wdata.slice = mfs_pkg::slice_of('0, slices_q);
          tm_wdata.allot = mfs_pkg::is_last('0, level_count_q) ? 16'd0
                                                               : mfs_pkg::allot_of('0, allots_q);
          if (fill_q[0] != CntW'(mfs_pkg::MaxTasks)) begin
            qm_we = 1'b1;
            qm_waddr = {LvW'(0), IdW'(head_q[0] + fill_q[0][IdW-1:0])};
            qm_wdata = count_q[IdW-1:0];
            fill_d[0] = fill_q[0] + CntW'(1);
          end
          count_d = count_q + CntW'(1);
        end
      end
      mfs_pkg::StScan: begin
        found_d = scan_found;
        lv_d    = scan_lv;
        time_d  = time_q + 32'd1;
        qm_raddr = {scan_lv, head_q[scan_lv]};
      end
      mfs_pkg::StReadQ: begin
        id_d = qm_rdata_q;
        tm_raddr = qm_rdata_q;
      end
      mfs_pkg::StReadTask: begin
        upd_d = tm_rdata_q;
        if (upd_d.burst != 16'd0) upd_d.burst = upd_d.burst - 16'd1;
        if (upd_d.slice != 8'd0) upd_d.slice = upd_d.slice - 8'd1;
        if (!mfs_pkg::is_last(lv_q, level_count_q) && upd_d.allot != 16'd0)
          upd_d.allot = upd_d.allot - 16'd1;
      end
      mfs_pkg::StUpdate: begin
        boost_d = (bmod_q == 16'd0);
        if (found_q) begin
          fin_d = (upd_q.burst == 16'd0);
          if (fin_d) begin
            turn_d = time_q - upd_q.stamp;
            head_d[lv_q] = head_q[lv_q] + IdW'(1);
            fill_d[lv_q] = fill_q[lv_q] - CntW'(1);
          end
          if (!boost_d && !fin_d) begin
            if (!mfs_pkg::is_last(lv_q, level_count_q) && upd_q.allot == 16'd0) begin
              rq_d = 1'b1;
              rq_lv_d = lv_q + LvW'(1);
              upd_d.slice = mfs_pkg::slice_of(rq_lv_d, slices_q);
              upd_d.allot = mfs_pkg::is_last(rq_lv_d, level_count_q) ? 16'd0
                            : mfs_pkg::allot_of(rq_lv_d, allots_q);
            end else if (upd_q.slice == 8'd0) begin
              rq_d = 1'b1;
              rq_lv_d = lv_q;
              upd_d.slice = mfs_pkg::slice_of(lv_q, slices_q);
            end
          end
          tm_we = 1'b1;
          tm_waddr = id_q;
          tm_wdata = upd_d;
        end
        if (boost_d) begin
          for (int i = 0; i < mfs_pkg::MaxLevels; i++) begin
            head_d[i] = '0;
            fill_d[i] = '0;
          end
          walk_d = '0;
        end
      end
      mfs_pkg::StRequeue: begin
        head_d[lv_q] = head_q[lv_q] + IdW'(1);
        fill_d[lv_q] = fill_q[lv_q] - CntW'(1);
        if (32'(rq_lv_q) < mfs_pkg::MaxLevels && fill_d[rq_lv_q] != CntW'(mfs_pkg::MaxTasks))
        begin
          qm_we = 1'b1;
          qm_waddr = {rq_lv_q, IdW'(head_d[rq_lv_q] + fill_d[rq_lv_q][IdW-1:0])};
          qm_wdata = id_q;
          fill_d[rq_lv_q] = fill_d[rq_lv_q] + CntW'(1);
        end
      end
      mfs_pkg::StBoostRead: begin
        tm_raddr = walk_q[IdW-1:0];
      end
      mfs_pkg::StBoostWrite: begin
        if (tm_rdata_q.burst != 16'd0) begin
          tm_we = 1'b1;
          tm_waddr = walk_q[IdW-1:0];
          tm_wdata = tm_rdata_q;
          tm_wdata.slice = mfs_pkg::slice_of('0, slices_q);
          tm_wdata.allot = mfs_pkg::is_last('0, level_count_q) ? 16'd0
                                                               : mfs_pkg::allot_of('0, allots_q);
          qm_we = 1'b1;
          qm_waddr = {LvW'(0), fill_q[0][IdW-1:0]};
          qm_wdata = walk_q[IdW-1:0];
          fill_d[0] = fill_q[0] + CntW'(1);
        end
        walk_d = walk_q + CntW'(1);
      end
      mfs_pkg::StDone: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfs_pkg::StIdle;
      time_q  <= '0;
      count_q <= '0;
      bmod_q  <= '0;
      for (int i = 0; i < mfs_pkg::MaxLevels; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      time_q  <= time_d;
      count_q <= count_d;
      bmod_q  <= bmod_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
    end
  end

  // Item payload and working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      burst_q <= burst_length_i;
    end
    lv_q <= lv_d; found_q <= found_d; id_q <= id_d; fin_q <= fin_d;
    turn_q <= turn_d; full_q <= full_d; boost_q <= boost_d; walk_q <= walk_d;
    upd_q <= upd_d; rq_lv_q <= rq_lv_d; rq_q <= rq_d;
  end

  // Result word.
  always_comb begin
    busy         = (state_q != mfs_pkg::StIdle) || rem_busy_q;
    done_o       = (state_q == mfs_pkg::StDone);
    task_id_o    = (full_q || (func_q == mfs_pkg::FuncTick && !found_q)) ? 6'd0 : 6'(id_q);
    ran_o        = (func_q == mfs_pkg::FuncTick) && found_q;
    finished_o   = ran_o && fin_q;
    turnaround_o = finished_o ? turn_q : 32'd0;
    run_level_o  = ran_o ? 3'(lv_q) : 3'd0;
    table_full_o = (func_q == mfs_pkg::FuncArrive) && full_q;
  end

endmodule
